// ===== rtl/core/cirb_pkg.sv =====
package cirb_pkg;

    // Search range: roots are searched in [0, 2**ROOT_BITS)
    localparam int ROOT_BITS = 21;

    // Field widths
    localparam int LIN_W  = 20;
    localparam int TGT_W  = 62;
    localparam int ROOT_W = 21;

    // Bit index counter, product and accumulator widths
    localparam int BIT_W  = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
    localparam int PROD_W = 2 * ROOT_W;
    localparam int ACC_W  = 64;

    // Operand selection for the shared multiplier
    typedef enum logic [1:0] {
        OP_SQ,   // t * t
        OP_LO,   // low half of t^2 times t
        OP_HI,   // high half of t^2 times t
        OP_LIN   // p * t
    } t_mul_op;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_LO   = 7'b0000100,
        S_HI   = 7'b0001000,
        S_LIN  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic             idle;      // ready for a new item
        logic             start;     // item accepted this cycle
        logic             mul_en;    // multiplier issues a product
        t_mul_op          op;        // multiplier operand select
        logic             sq_save;   // keep high half of t^2
        logic             acc_load;  // acc <= low partial product
        logic             acc_add;   // acc += high partial product << ROOT_W
        logic             cmp;       // compare trial cubic with q
        logic             out_load;  // move result to the output register
        logic [BIT_W-1:0] bit_idx;   // bit under trial
    } t_ctrl;

endpackage

// ===== rtl/core/cirb_mul.sv =====
module cirb_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cirb_pkg::ROOT_W-1:0]  i_a,
    input  logic [cirb_pkg::ROOT_W-1:0]  i_b,
    output logic [cirb_pkg::PROD_W-1:0]  o_prod
);

    logic [cirb_pkg::PROD_W-1:0] r_prod;

    // Shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= cirb_pkg::PROD_W'(i_a) * cirb_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/cirb_ctrl.sv =====
module cirb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output cirb_pkg::t_ctrl o_ctrl
);

    cirb_pkg::t_state              r_state, n_state;
    logic [cirb_pkg::BIT_W-1:0]    r_bit, n_bit;

    // Next state: five steps per trial bit, top bit first
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        unique case (r_state)
            cirb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cirb_pkg::S_SQ;
                    n_bit   = cirb_pkg::BIT_W'(cirb_pkg::ROOT_BITS - 1);
                end
            end
            cirb_pkg::S_SQ:  n_state = cirb_pkg::S_LO;
            cirb_pkg::S_LO:  n_state = cirb_pkg::S_HI;
            cirb_pkg::S_HI:  n_state = cirb_pkg::S_LIN;
            cirb_pkg::S_LIN: n_state = cirb_pkg::S_CMP;
            cirb_pkg::S_CMP: begin
                if (r_bit == '0) begin
                    n_state = cirb_pkg::S_DONE;
                end else begin
                    n_state = cirb_pkg::S_SQ;
                    n_bit   = r_bit - 1'b1;
                end
            end
            cirb_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = cirb_pkg::S_IDLE;
                end
            end
            default: n_state = cirb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cirb_pkg::S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    // Control decode
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.idle     = (r_state == cirb_pkg::S_IDLE);
        o_ctrl.start    = (r_state == cirb_pkg::S_IDLE) && i_in_valid;
        o_ctrl.bit_idx  = r_bit;
        o_ctrl.op       = cirb_pkg::OP_SQ;
        unique case (r_state)
            cirb_pkg::S_SQ: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.op     = cirb_pkg::OP_SQ;
            end
            cirb_pkg::S_LO: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.op      = cirb_pkg::OP_LO;
                o_ctrl.sq_save = 1'b1;
            end
            cirb_pkg::S_HI: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.op       = cirb_pkg::OP_HI;
                o_ctrl.acc_load = 1'b1;
            end
            cirb_pkg::S_LIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.op      = cirb_pkg::OP_LIN;
                o_ctrl.acc_add = 1'b1;
            end
            cirb_pkg::S_CMP:  o_ctrl.cmp      = 1'b1;
            cirb_pkg::S_DONE: o_ctrl.out_load = i_out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/cubic_integer_root_bisection_top.sv =====
// Integer root of x^3 + p*x = q by bisection, one root bit per trial.
// A new item is taken only in idle, after the previous result has moved to the
// output register, which waits while a held result is still stalled.
// Each trial takes four passes through the single 21x21 multiplier plus one
// add-and-compare step.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; no clearing pass.
module cubic_integer_root_bisection_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cirb_pkg::LIN_W-1:0]   i_lin_coef,
    input  logic [cirb_pkg::TGT_W-1:0]   i_target,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [cirb_pkg::ROOT_W-1:0]  o_root
);

    cirb_pkg::t_ctrl                w_ctrl;
    logic                           w_out_free;
    logic [cirb_pkg::ROOT_W-1:0]    w_trial;
    logic [cirb_pkg::ROOT_W-1:0]    w_mul_a;
    logic [cirb_pkg::PROD_W-1:0]    w_prod;
    logic [cirb_pkg::ACC_W-1:0]     w_sum;
    logic                           w_le;
    logic                           w_eq;

    logic [cirb_pkg::LIN_W-1:0]     r_p;
    logic [cirb_pkg::TGT_W-1:0]     r_q;
    logic [cirb_pkg::ROOT_W-1:0]    r_x;
    logic                           r_eq;
    logic [cirb_pkg::ROOT_W-1:0]    r_sq_hi;
    logic [cirb_pkg::ACC_W-1:0]     r_acc;
    logic                           r_out_valid;
    logic                           r_found;
    logic [cirb_pkg::ROOT_W-1:0]    r_root;

    assign w_out_free = !r_out_valid || !i_out_stall;

    cirb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Trial value: current root with the bit under test set
    assign w_trial = r_x | (cirb_pkg::ROOT_W'(1) << w_ctrl.bit_idx);

    // Multiplier operand select; second operand is always the trial value
    always_comb begin
        unique case (w_ctrl.op)
            cirb_pkg::OP_SQ:  w_mul_a = w_trial;
            cirb_pkg::OP_LO:  w_mul_a = w_prod[cirb_pkg::ROOT_W-1:0];
            cirb_pkg::OP_HI:  w_mul_a = r_sq_hi;
            cirb_pkg::OP_LIN: w_mul_a = cirb_pkg::ROOT_W'(r_p);
            default:          w_mul_a = w_trial;
        endcase
    end

    cirb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_trial),
        .o_prod (w_prod)
    );

    // Final sum: t^3 already in acc, p*t in the product register
    assign w_sum = r_acc + cirb_pkg::ACC_W'(w_prod);
    assign w_le  = (w_sum <= cirb_pkg::ACC_W'(r_q));
    assign w_eq  = (w_sum == cirb_pkg::ACC_W'(r_q));

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.start) begin
            r_p  <= i_lin_coef;
            r_q  <= i_target;
            r_x  <= '0;
            // x = 0 is the root when q is zero
            r_eq <= (i_target == '0);
        end
        if (w_ctrl.sq_save) begin
            r_sq_hi <= w_prod[cirb_pkg::PROD_W-1:cirb_pkg::ROOT_W];
        end
        if (w_ctrl.acc_load) begin
            r_acc <= cirb_pkg::ACC_W'(w_prod);
        end
        if (w_ctrl.acc_add) begin
            r_acc <= r_acc
                   + cirb_pkg::ACC_W'({w_prod, {cirb_pkg::ROOT_W{1'b0}}});
        end
        // Keep the bit when the cubic stays at or below q
        if (w_ctrl.cmp && w_le) begin
            r_x  <= w_trial;
            r_eq <= w_eq;
        end
        if (w_ctrl.out_load) begin
            r_found <= r_eq;
            r_root  <= r_eq ? r_x : '0;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = !w_ctrl.idle;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_root      = r_root;

`ifndef SYNTHESIS
    // Block stays busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // A result appears only at the end of a search
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_in_stall))
        else $error("result issued while idle");

    // Root reads zero when none was found
    a_root_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_root == '0))
        else $error("nonzero root without a found root");

    // Output register is only reloaded when free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while held");
`endif

endmodule
